// ===== rtl/core/kst_pkg.sv =====
// Shared constants, codes, command and status types for the spanning tree engine.
`timescale 1ns / 1ps
package kst_pkg;
  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 8;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int CW           = VW + 1;
  localparam int EDGE_COUNT   = (MAX_VERTICES * (MAX_VERTICES - 1)) / 2;
  localparam int EW           = $clog2(EDGE_COUNT);
  localparam int KW           = WEIGHT_BITS + EW;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TREE  = 2'd2;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_EDGE = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic CFG_NUM_VERTICES = 1'b0;
  localparam logic CFG_DISCONNECTED = 1'b1;

  typedef struct packed {
    logic latch_req;
    logic do_write;
    logic rd_issue;
    logic tree_init;
    logic scan_init;
    logic scan_issue;
    logic pick;
    logic relabel;
    logic emit_ack;
    logic emit_rd;
    logic emit_edge;
    logic emit_done;
  } kst_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       issue_last;
    logic       found;
    logic       trees_one;
    logic       labels_equal;
  } kst_status_t;

  function automatic logic [EW-1:0] row_base(input logic [VW-1:0] a);
    logic [EW+VW:0] prod;
    prod = (EW+VW+1)'(a) * (EW+VW+1)'(2 * MAX_VERTICES - 1 - int'(a));
    return EW'(prod >> 1);
  endfunction
endpackage

// ===== rtl/core/kst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/kst_datapath.sv =====
// Datapath: edge store, configuration, scan and compare, tree labels and result registers.
`timescale 1ns / 1ps
module kst_datapath import kst_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kst_cmd_t               cmd,
  output kst_status_t            status,
  input  logic [1:0]             in_req_type,
  input  logic [3:0]             in_vertex_a,
  input  logic [3:0]             in_vertex_b,
  input  logic signed [7:0]      in_edge_weight_in,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  output logic                   out_valid,
  output logic [1:0]             out_result_kind,
  output logic [3:0]             out_end_a,
  output logic [3:0]             out_end_b,
  output logic signed [7:0]      out_weight_out,
  output logic [4:0]             out_tree_count,
  output logic                   out_bad_vertex,
  output logic                   out_last
);
  logic [4:0]             nv_r;
  logic [7:0]             disc_r;
  logic [1:0]             req_type_r;
  logic [VW-1:0]          req_a_r, req_b_r;
  logic [WEIGHT_BITS-1:0] req_w_r;
  logic [EW-1:0]          req_idx;
  logic                   same_v;
  logic [CW-1:0]          n_eff;

  logic [EW-1:0]          raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic                   rvalid_r;
  logic [EDGE_COUNT-1:0]  vbits_r;
  logic [WEIGHT_BITS-1:0] w_rd;
  logic                   wr_en;

  logic [VW-1:0]          sc_a_r, sc_b_r, p_a_r, p_b_r;
  logic [EW-1:0]          sc_idx_r, p_idx_r;
  logic                   p_vld_r;
  logic [KW-1:0]          cand_key, best_key_r, last_key_r;
  logic                   found_r, have_last_r, cand;
  logic [VW-1:0]          best_a_r, best_b_r;
  logic [WEIGHT_BITS-1:0] best_w_r, disc_w;

  logic [VW-1:0]          label_r [MAX_VERTICES];
  logic [VW-1:0]          la_r, lb;
  logic [CW-1:0]          trees_r;

  logic                   out_valid_r, out_bad_r, out_last_r;
  logic [1:0]             out_kind_r;
  logic [3:0]             out_a_r, out_b_r;
  logic [7:0]             out_w_r;
  logic [4:0]             out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r   <= 5'(MAX_VERTICES);
      disc_r <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_VERTICES: nv_r   <= cfg_data[4:0];
        CFG_DISCONNECTED: disc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nv_r < 5'd2) begin
      n_eff = CW'(2);
    end else if (CW'(nv_r) > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(nv_r);
    end
  end

  assign disc_w = WEIGHT_BITS'($signed(disc_r));

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r <= in_req_type;
      if (in_vertex_a > in_vertex_b) begin
        req_a_r <= VW'(in_vertex_b);
        req_b_r <= VW'(in_vertex_a);
      end else begin
        req_a_r <= VW'(in_vertex_a);
        req_b_r <= VW'(in_vertex_b);
      end
      req_w_r <= WEIGHT_BITS'(in_edge_weight_in);
    end
  end

  assign same_v  = (req_a_r == req_b_r);
  assign req_idx = row_base(req_a_r) + EW'(req_b_r) - EW'(req_a_r) - EW'(1);
  assign wr_en   = cmd.do_write && !same_v;
  assign raddr   = cmd.rd_issue ? req_idx : sc_idx_r;

  kst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(EDGE_COUNT)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (req_idx),
    .wdata (req_w_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r <= '0;
    end else if (wr_en) begin
      vbits_r[req_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rvalid_r <= vbits_r[raddr];
  end

  assign w_rd = rvalid_r ? rdata : {WEIGHT_BITS{1'b1}};

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      sc_a_r   <= '0;
      sc_b_r   <= VW'(1);
      sc_idx_r <= '0;
    end else if (cmd.scan_issue) begin
      sc_idx_r <= sc_idx_r + EW'(1);
      if (sc_b_r == VW'(MAX_VERTICES - 1)) begin
        sc_a_r <= sc_a_r + VW'(1);
        sc_b_r <= sc_a_r + VW'(2);
      end else begin
        sc_b_r <= sc_b_r + VW'(1);
      end
    end
    p_a_r   <= sc_a_r;
    p_b_r   <= sc_b_r;
    p_idx_r <= sc_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.scan_issue;
    end
  end

  assign cand_key = {w_rd ^ {1'b1, {(WEIGHT_BITS-1){1'b0}}}, p_idx_r};
  assign cand = p_vld_r && (CW'(p_b_r) < n_eff) && (w_rd != disc_w)
             && (!have_last_r || cand_key > last_key_r)
             && (!found_r || cand_key < best_key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      have_last_r <= 1'b0;
    end else begin
      if (cmd.tree_init) begin
        have_last_r <= 1'b0;
      end else if (cmd.pick) begin
        have_last_r <= 1'b1;
      end
      if (cmd.scan_init) begin
        found_r <= 1'b0;
      end else if (cand) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      best_key_r <= cand_key;
      best_a_r   <= p_a_r;
      best_b_r   <= p_b_r;
      best_w_r   <= w_rd;
    end
    if (cmd.pick) begin
      last_key_r <= best_key_r;
      la_r       <= label_r[best_a_r];
    end
  end

  assign lb = label_r[best_b_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (cmd.tree_init) begin
        label_r[i] <= VW'(i);
      end else if (cmd.relabel && label_r[i] == lb) begin
        label_r[i] <= la_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trees_r <= '0;
    end else if (cmd.tree_init) begin
      trees_r <= n_eff;
    end else if (cmd.relabel) begin
      trees_r <= trees_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_ack | cmd.emit_rd | cmd.emit_edge | cmd.emit_done;
    end
    out_kind_r <= KIND_ACK;
    out_a_r    <= '0;
    out_b_r    <= '0;
    out_w_r    <= '0;
    out_cnt_r  <= '0;
    out_bad_r  <= 1'b0;
    out_last_r <= 1'b1;
    if (cmd.emit_ack) begin
      out_bad_r <= same_v;
    end else if (cmd.emit_rd) begin
      out_kind_r <= KIND_READ;
      out_w_r    <= same_v ? 8'd0 : 8'(w_rd);
    end else if (cmd.emit_edge) begin
      out_kind_r <= KIND_EDGE;
      out_a_r    <= 4'(best_a_r);
      out_b_r    <= 4'(best_b_r);
      out_w_r    <= 8'(best_w_r);
      out_last_r <= 1'b0;
    end else if (cmd.emit_done) begin
      out_kind_r <= KIND_DONE;
      out_cnt_r  <= 5'(trees_r);
    end
  end

  assign status.req_type     = req_type_r;
  assign status.issue_last   = (sc_a_r == VW'(MAX_VERTICES - 2))
                            && (sc_b_r == VW'(MAX_VERTICES - 1));
  assign status.found        = found_r;
  assign status.trees_one    = (trees_r <= CW'(1));
  assign status.labels_equal = (lb == la_r);

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_end_a       = out_a_r;
  assign out_end_b       = out_b_r;
  assign out_weight_out  = out_w_r;
  assign out_tree_count  = out_cnt_r;
  assign out_bad_vertex  = out_bad_r;
  assign out_last        = out_last_r;
endmodule

// ===== rtl/core/kst_controller.sv =====
// Controller state machine sequencing writes, reads and the spanning tree search.
`timescale 1ns / 1ps
module kst_controller import kst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  kst_status_t status,
  output kst_cmd_t    cmd
);
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DECODE   = 4'd1;
  localparam logic [3:0] ST_WRITE    = 4'd2;
  localparam logic [3:0] ST_RD_ISSUE = 4'd3;
  localparam logic [3:0] ST_RD_DATA  = 4'd4;
  localparam logic [3:0] ST_CHECK    = 4'd5;
  localparam logic [3:0] ST_SCAN     = 4'd6;
  localparam logic [3:0] ST_SCAN_END = 4'd7;
  localparam logic [3:0] ST_PICK     = 4'd8;
  localparam logic [3:0] ST_MERGE    = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch_req = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.req_type)
          REQ_WRITE: state_nxt = ST_WRITE;
          REQ_READ:  state_nxt = ST_RD_ISSUE;
          REQ_TREE: begin
            cmd.tree_init = 1'b1;
            state_nxt     = ST_CHECK;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_WRITE: begin
        cmd.do_write = 1'b1;
        cmd.emit_ack = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_CHECK: begin
        if (status.trees_one) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = ST_PICK;
      ST_PICK: begin
        if (status.found) begin
          cmd.pick  = 1'b1;
          state_nxt = ST_MERGE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MERGE: begin
        if (!status.labels_equal) begin
          cmd.relabel   = 1'b1;
          cmd.emit_edge = 1'b1;
        end
        state_nxt = ST_CHECK;
      end
      ST_DONE: begin
        cmd.emit_done = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);
endmodule

// ===== rtl/core/kruskal_spanning_tree_engine.sv =====
// Top level of the Kruskal spanning tree engine: controller and datapath.
//
//   Channel   Ports                                  Beat taken when
//   input     start, busy, in_*                      start high and busy low
//   result    out_valid, out_*                       out_valid high, one cycle
//   config    cfg_we, cfg_index, cfg_data            cfg_we high
//
// A write passes the decode and write states, a read the decode, read issue and
// read data states, before the result beat. A tree request rescans all 120 store
// entries once for each edge it considers and emits at most 15 tree edges, then done.
// Reset is synchronous; the edge store reads as the disconnected marker at once.
// Results cannot be stalled: each beat is shown for exactly one cycle.
`timescale 1ns / 1ps
module kruskal_spanning_tree_engine import kst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_vertex_a,
  input  logic [3:0]         in_vertex_b,
  input  logic signed [7:0]  in_edge_weight_in,
  output logic               out_valid,
  output logic [1:0]         out_result_kind,
  output logic [3:0]         out_end_a,
  output logic [3:0]         out_end_b,
  output logic signed [7:0]  out_weight_out,
  output logic [4:0]         out_tree_count,
  output logic               out_bad_vertex,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  kst_cmd_t    cmd;
  kst_status_t status;

  kst_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  kst_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_req_type       (in_req_type),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .in_edge_weight_in (in_edge_weight_in),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_end_a         (out_end_a),
    .out_end_b         (out_end_b),
    .out_weight_out    (out_weight_out),
    .out_tree_count    (out_tree_count),
    .out_bad_vertex    (out_bad_vertex),
    .out_last          (out_last)
  );
endmodule

// ===== rtl/core/kst_checker.sv =====
// Port-level checker for the spanning tree engine, bound to the top level.
`timescale 1ns / 1ps
module kst_checker import kst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_result_kind,
  input logic [4:0] out_tree_count,
  input logic       out_last
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after an accepted beat");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("final beat shown while still busy");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_DONE |-> out_last && out_tree_count != 5'd0)
    else $error("done beat without last flag or with zero tree count");

  a_edge_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_EDGE |-> !out_last && busy)
    else $error("tree edge beat marked last or shown while idle");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result beat directly after reset");
endmodule

bind kruskal_spanning_tree_engine kst_checker u_kst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_tree_count  (out_tree_count),
  .out_last        (out_last)
);
